@@ design/ise_pkg.sv @@
// Shared operation codes, status codes and controller/datapath interface types.
package ise_pkg;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_CHANGE = 3'd3;
  localparam logic [2:0] OP_SWAP   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_BADPOS   = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;

  localparam int FIELD_W    = 5;
  localparam int WORD_W     = 32;
  localparam int CAP_DEFAULT = 16;

  typedef struct packed {
    logic accept;
    logic swap_first;
    logic swap_second;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic swap_go;
  } dp_status_t;

endpackage

@@ design/ise_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ design/ise_regs.sv @@
// Configuration register file holding the stack capacity.
module ise_regs import ise_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [FIELD_W-1:0] capacity
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= FIELD_W'(CAP_DEFAULT);
    end else if (wr_hit) begin
      capacity <= pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(32-FIELD_W){1'b0}}, capacity};
    end
  end

endmodule

@@ design/ise_ctrl.sv @@
// Controller state machine sequencing single-word operations and the two-step interchange.
module ise_ctrl import ise_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t dp_st,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RESP  = 2'd1;
  localparam logic [1:0] S_SWAP1 = 2'd2;
  localparam logic [1:0] S_SWAP2 = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = dp_st.swap_go ? S_SWAP1 : S_RESP;
        end
      end
      S_RESP:  state_next = S_IDLE;
      S_SWAP1: state_next = S_SWAP2;
      S_SWAP2: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy            = (state != S_IDLE);
  assign cmd.accept      = (state == S_IDLE) && start;
  assign cmd.swap_first  = (state == S_SWAP1);
  assign cmd.swap_second = (state == S_SWAP2);
  assign cmd.emit        = (state == S_RESP) || (state == S_SWAP2);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> busy)
    else $error("controller did not go busy after taking a word");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !busy)
    else $error("controller stayed busy after its result");

  a_swap_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_first |=> cmd.swap_second)
    else $error("interchange second write step missing");

  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !dp_st.swap_go) |=> cmd.emit)
    else $error("result of a single-step operation not given in the next cycle");

endmodule

@@ design/ise_dp.sv @@
// Datapath: fill count, status decode, entry store and result formatting.
module ise_dp import ise_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         dp_st,
  input  logic [FIELD_W-1:0] capacity,
  input  logic [2:0]         operation,
  input  logic signed [WORD_W-1:0] data_value,
  input  logic [FIELD_W-1:0] depth_first,
  input  logic [FIELD_W-1:0] depth_second,
  output logic signed [WORD_W-1:0] read_value,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] fill_count
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;

  logic [CW-1:0]     count;
  logic [CMPW-1:0]   count_ext;
  logic [CMPW-1:0]   d1_ext;
  logic [CMPW-1:0]   d2_ext;
  logic [CMPW-1:0]   cap_ext;
  logic [FIELD_W-1:0] cap_eff;
  logic              is_empty;
  logic              is_full;
  logic              d1_ok;
  logic              d2_ok;
  logic [1:0]        st_new;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [WORD_W-1:0] rd_data_a;
  logic [WORD_W-1:0] rd_data_b;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [2:0]        op_q;
  logic [1:0]        status_q;
  logic [AW-1:0]     slot_a_q;
  logic [AW-1:0]     slot_b_q;
  logic [WORD_W-1:0] hold_a;

  assign count_ext = CMPW'(count);
  assign d1_ext    = CMPW'(depth_first);
  assign d2_ext    = CMPW'(depth_second);
  assign cap_eff   = (capacity == '0) ? FIELD_W'(1) : capacity;
  assign cap_ext   = CMPW'(cap_eff);
  assign is_empty  = (count == '0);
  assign is_full   = (count_ext >= cap_ext) || (count_ext >= CMPW'(STACK_DEPTH));
  assign d1_ok     = (depth_first != '0) && (d1_ext <= count_ext);
  assign d2_ok     = (depth_second != '0) && (d2_ext <= count_ext);

  always_comb begin
    case (operation) inside
      OP_PUSH: st_new = is_full ? ST_OVERFLOW : ST_OK;
      OP_POP:  st_new = is_empty ? ST_EMPTY : ST_OK;
      OP_PEEK, OP_CHANGE: begin
        if (is_empty) begin
          st_new = ST_EMPTY;
        end else begin
          st_new = d1_ok ? ST_OK : ST_BADPOS;
        end
      end
      OP_SWAP: begin
        if (is_empty) begin
          st_new = ST_EMPTY;
        end else begin
          st_new = (d1_ok && d2_ok) ? ST_OK : ST_BADPOS;
        end
      end
      default: st_new = ST_BADPOS;
    endcase
  end

  assign dp_st.swap_go = (operation == OP_SWAP) && (st_new == ST_OK);

  assign rd_addr_a = (operation == OP_POP) ? AW'(count_ext - CMPW'(1))
                                           : AW'(count_ext - d1_ext);
  assign rd_addr_b = AW'(count_ext - d2_ext);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_a;
    wr_data = data_value;
    if (cmd.accept && (st_new == ST_OK) && (operation == OP_PUSH)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
    end else if (cmd.accept && (st_new == ST_OK) && (operation == OP_CHANGE)) begin
      wr_en   = 1'b1;
    end else if (cmd.swap_first) begin
      wr_en   = 1'b1;
      wr_addr = slot_a_q;
      wr_data = rd_data_b;
    end else if (cmd.swap_second) begin
      wr_en   = 1'b1;
      wr_addr = slot_b_q;
      wr_data = hold_a;
    end
  end

  ise_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && (st_new == ST_OK)) begin
      if (operation == OP_PUSH) begin
        count <= count + CW'(1);
      end else if (operation == OP_POP) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= operation;
      status_q <= st_new;
      slot_a_q <= rd_addr_a;
      slot_b_q <= rd_addr_b;
    end
    if (cmd.swap_first) begin
      hold_a <= rd_data_a;
    end
  end

  assign read_value = (((op_q == OP_POP) || (op_q == OP_PEEK)) && (status_q == ST_OK))
                      ? $signed(rd_data_a) : '0;
  assign status     = status_q;
  assign fill_count = FIELD_W'(count);

endmodule

@@ design/indexed_stack_engine_unit.sv @@
// Top level of the indexed stack engine: configuration port, controller and datapath.
// An operation is taken when start is high and busy is low; its result word appears
// with done in the next cycle, or, for an interchange that goes ahead, in state S_SWAP2.
// No new operation is taken until its result has been given; an interchange makes two
// writes in turn (S_SWAP1, S_SWAP2), as they share the store's single write port.
// Results cannot be stalled. Reset empties the stack and sets the capacity to 16;
// stored entries are not cleared.
module indexed_stack_engine_unit import ise_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [WORD_W-1:0] data_value,
  input  logic [FIELD_W-1:0] depth_first,
  input  logic [FIELD_W-1:0] depth_second,
  output logic               done,
  output logic signed [WORD_W-1:0] read_value,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] fill_count
);

  ctrl_cmd_t          cmd;
  dp_status_t         dp_st;
  logic [FIELD_W-1:0] capacity;

  ise_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  ise_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .dp_st (dp_st),
    .cmd   (cmd),
    .busy  (busy)
  );

  ise_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_st        (dp_st),
    .capacity     (capacity),
    .operation    (operation),
    .data_value   (data_value),
    .depth_first  (depth_first),
    .depth_second (depth_second),
    .read_value   (read_value),
    .status       (status),
    .fill_count   (fill_count)
  );

  assign done = cmd.emit;

endmodule

@@ tb/sv/indexed_stack_engine_unit_test.sv @@
// Self-checking testbench for the indexed stack engine: directed and random operations.
`timescale 1ns / 1ps

module indexed_stack_engine_unit_test;
  import ise_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [2:0] CAPACITY_ADDR = 3'(4 * REG_CAPACITY);
  localparam logic [2:0] OP_FIRST_UNUSED = OP_SWAP + 3'd1;
  localparam logic [2:0] OP_LAST_CODE = 3'd7;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0] status;
    logic [4:0] fill;
  } stack_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [2:0] operation = '0;
  logic signed [31:0] data_value = '0;
  logic [4:0] depth_first = '0;
  logic [4:0] depth_second = '0;
  logic done;
  logic signed [31:0] read_value;
  logic [1:0] status;
  logic [4:0] fill_count;

  logic signed [31:0] model_entries [DEPTH];
  int unsigned model_fill = 0;
  logic [4:0] model_capacity = 5'd16;

  stack_word_t pending_words [$];
  bit gaps_on = 1'b1;
  int error_count = 0;
  int words_sent = 0;
  int pushes_sent = 0;
  int words_checked = 0;
  int capacity_writes = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  indexed_stack_engine_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .operation(operation), .data_value(data_value),
    .depth_first(depth_first), .depth_second(depth_second),
    .done(done), .read_value(read_value), .status(status), .fill_count(fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stack_word_t apply_stack_op(logic [2:0] op, logic signed [31:0] data,
                                                  logic [4:0] d1, logic [4:0] d2);
    stack_word_t w;
    int unsigned cap;
    int unsigned sa;
    int unsigned sb;
    logic signed [31:0] tmp;
    cap = (model_capacity == 0) ? 1 : (model_capacity > DEPTH) ? DEPTH : model_capacity;
    w.value = '0;
    w.status = ST_OK;
    if (op == OP_PUSH) begin
      if (model_fill >= cap) begin
        w.status = ST_OVERFLOW;
      end else begin
        model_entries[model_fill] = data;
        model_fill++;
      end
    end else if (op == OP_POP || op == OP_PEEK || op == OP_CHANGE || op == OP_SWAP) begin
      if (model_fill == 0) begin
        w.status = ST_EMPTY;
      end else if (op == OP_POP) begin
        w.value = model_entries[model_fill - 1];
        model_fill--;
      end else if (d1 < 1 || d1 > model_fill ||
                   (op == OP_SWAP && (d2 < 1 || d2 > model_fill))) begin
        w.status = ST_BADPOS;
      end else begin
        sa = model_fill - d1;
        sb = model_fill - d2;
        if (op == OP_PEEK) begin
          w.value = model_entries[sa];
        end else if (op == OP_CHANGE) begin
          model_entries[sa] = data;
        end else begin
          tmp = model_entries[sa];
          model_entries[sa] = model_entries[sb];
          model_entries[sb] = tmp;
        end
      end
    end else begin
      w.status = ST_BADPOS;
    end
    w.fill = 5'(model_fill);
    return w;
  endfunction

  // Presents one operation and holds it until the engine takes it.
  task automatic send_word(logic [2:0] op, logic signed [31:0] data,
                           logic [4:0] d1, logic [4:0] d2);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    data_value <= data;
    depth_first <= d1;
    depth_second <= d2;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_words.push_back(apply_stack_op(op, data, d1, d2));
    words_sent++;
    if (op == OP_PUSH) pushes_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CAPACITY_ADDR;
    pwdata <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_capacity = cap;
    capacity_writes++;
  endtask

  function automatic logic signed [31:0] pick_data();
    case ($urandom_range(0, 19))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_depth();
    if (model_fill > 0 && $urandom_range(0, 9) < 8) return 5'($urandom_range(1, model_fill));
    return 5'($urandom_range(0, 31));
  endfunction

  always @(posedge clk) begin
    stack_word_t want;
    if (!rst && done === 1'b1) begin
      if (pending_words.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected result word value=%0d status=%0d fill=%0d",
                   read_value, status, fill_count);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        status_tally[want.status]++;
        if (read_value !== want.value || status !== want.status || fill_count !== want.fill) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: word %0d expected value=%0d status=%0d fill=%0d, got %0d/%0d/%0d",
                     words_checked, want.value, want.status, want.fill,
                     read_value, status, fill_count);
        end
      end
    end
  end

  task automatic test_directed_operations();
    send_word(OP_POP, $urandom, 5'd1, 5'd1);
    send_word(OP_PEEK, $urandom, 5'd1, 5'd1);
    send_word(OP_CHANGE, $urandom, 5'd1, 5'd1);
    send_word(OP_SWAP, $urandom, 5'd1, 5'd1);
    send_word(OP_FIRST_UNUSED, $urandom, 5'd1, 5'd1);
    send_word(OP_PUSH, WORD_MIN, 5'd0, 5'd31);
    send_word(OP_PUSH, WORD_MAX, 5'd31, 5'd0);
    send_word(OP_PUSH, '0, 5'd1, 5'd1);
    send_word(OP_PUSH, -32'sd1, 5'd1, 5'd1);
    send_word(OP_PUSH, 32'sh5a5a_a5a5, 5'd1, 5'd1);
    send_word(OP_PEEK, $urandom, 5'd1, 5'd31);
    send_word(OP_PEEK, $urandom, 5'd5, 5'd0);
    send_word(OP_PEEK, $urandom, 5'd0, 5'd1);
    send_word(OP_PEEK, $urandom, 5'd31, 5'd1);
    send_word(OP_CHANGE, 32'sh1234_5678, 5'd2, 5'd0);
    send_word(OP_CHANGE, $urandom, 5'd6, 5'd1);
    send_word(OP_SWAP, $urandom, 5'd1, 5'd5);
    send_word(OP_SWAP, $urandom, 5'd3, 5'd3);
    send_word(OP_SWAP, $urandom, 5'd2, 5'd0);
    send_word(OP_SWAP, $urandom, 5'd31, 5'd1);
    send_word(OP_LAST_CODE, $urandom, 5'd1, 5'd1);
    repeat (6) send_word(OP_POP, $urandom, 5'd1, 5'd1);
  endtask

  task automatic test_capacity_limits();
    wait_idle();
    write_capacity(5'd1);
    send_word(OP_PUSH, 32'sh0bad_cafe, 5'd1, 5'd1);
    send_word(OP_PUSH, 32'sh7777_0000, 5'd1, 5'd1);
    send_word(OP_POP, $urandom, 5'd1, 5'd1);
    wait_idle();
    write_capacity(5'd0);
    send_word(OP_PUSH, -32'sd7, 5'd1, 5'd1);
    send_word(OP_PUSH, 32'sd9, 5'd1, 5'd1);
    send_word(OP_PEEK, $urandom, 5'd1, 5'd1);
    send_word(OP_POP, $urandom, 5'd1, 5'd1);
  endtask

  // Phases vary the push weight between filling and draining so that full, lowered and oversize
  // capacities are all met with entries already held.
  task automatic test_random_operations();
    logic [4:0] phase_caps [10] = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd16, 5'd0, 5'd8, 5'd16,
                                    5'd2, 5'd12};
    int push_weights [10] = '{75, 60, 45, 40, 70, 50, 35, 65, 50, 40};
    int pick;
    logic [2:0] op;
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      write_capacity(phase_caps[phase]);
      gaps_on = (phase % 3 != 2);
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        else if (pick < 4 + push_weights[phase]) op = OP_PUSH;
        else op = 3'($urandom_range(OP_POP, OP_SWAP));
        send_word(op, pick_data(), pick_depth(), pick_depth());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_operations();
    test_capacity_limits();
    test_random_operations();
    wait_idle();
    $display("Sent %0d operations (%0d pushes) over %0d capacity settings.",
             words_sent, pushes_sent, capacity_writes);
    $display("Checked %0d results: %0d ok, %0d overflow, %0d empty, %0d bad position.",
             words_checked, status_tally[ST_OK], status_tally[ST_OVERFLOW],
             status_tally[ST_EMPTY], status_tally[ST_BADPOS]);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("indexed_stack_engine_unit_test OK");
    end else begin
      $display("indexed_stack_engine_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_words.size());
    $display("indexed_stack_engine_unit_test NOT OK");
    $finish;
  end

endmodule
